>>> hdl/triangle_median_split_axis_select_unit_assert.svh
// assertion macros for the median split axis select unit
`ifndef TRIANGLE_MEDIAN_SPLIT_AXIS_SELECT_UNIT_ASSERT_SVH
`define TRIANGLE_MEDIAN_SPLIT_AXIS_SELECT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TMSAS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TMSAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMSAS_ASSERT_SAME(label, ante, cons, msg)
`define TMSAS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/tmsas_pkg.sv
`default_nettype none

package tmsas_pkg;

  localparam int MAX_TRIANGLES = 65536;
  localparam int CNT_W = 17;
  localparam int NUM_AXES = 3;
  localparam logic [CNT_W-1:0] COUNT_CAP =
      CNT_W'((MAX_TRIANGLES < 131071) ? MAX_TRIANGLES : 131071);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_EXCLUDED_AXIS = 2'd3;

  typedef logic signed [31:0] coord_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
    logic   last_triangle;
  } tri_t;

  typedef struct packed {
    logic       low_on_x;
    logic       low_on_y;
    logic       low_on_z;
    logic       decision_valid;
    logic [1:0] chosen_axis;
    logic       use_index_halves;
    count_t     low_count;
    count_t     high_count;
  } res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  typedef struct packed {
    count_t lo;
    count_t hi;
  } side_cnt_t;

  typedef side_cnt_t [NUM_AXES-1:0] cnt_set_t;

  // counter bank control
  typedef struct packed {
    logic                step;
    logic                clear;
    logic [NUM_AXES-1:0] en;
    logic [NUM_AXES-1:0] low;
  } upd_t;

  typedef struct packed {
    logic [1:0] axis;
    logic       halves;
    count_t     lo;
    count_t     hi;
  } decision_t;

endpackage

`default_nettype wire

>>> hdl/tmsas_if.sv
`default_nettype none

interface tmsas_tri_if;
  logic            valid;
  logic            ready;
  tmsas_pkg::tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmsas_res_if;
  logic            valid;
  logic            ready;
  tmsas_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmsas_cfg_if;
  logic            valid;
  logic            ready;
  tmsas_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/tmsas_classify.sv
`default_nettype none

module tmsas_classify (
  input  tmsas_pkg::tri_t                      tri_i,
  input  tmsas_pkg::coord_t                    center_x_i,
  input  tmsas_pkg::coord_t                    center_y_i,
  input  tmsas_pkg::coord_t                    center_z_i,
  input  logic [1:0]                           excl_i,
  output logic [tmsas_pkg::NUM_AXES-1:0]       en_o,
  output logic [tmsas_pkg::NUM_AXES-1:0]       low_o
);

  logic [2:0] bx, by, bz;
  logic [2:0] maj;

  assign bx = {tri_i.v3_x < center_x_i, tri_i.v2_x < center_x_i, tri_i.v1_x < center_x_i};
  assign by = {tri_i.v3_y < center_y_i, tri_i.v2_y < center_y_i, tri_i.v1_y < center_y_i};
  assign bz = {tri_i.v3_z < center_z_i, tri_i.v2_z < center_z_i, tri_i.v1_z < center_z_i};

  // two of three corners below the center
  assign maj[0] = (bx[0] & bx[1]) | (bx[0] & bx[2]) | (bx[1] & bx[2]);
  assign maj[1] = (by[0] & by[1]) | (by[0] & by[2]) | (by[1] & by[2]);
  assign maj[2] = (bz[0] & bz[1]) | (bz[0] & bz[2]) | (bz[1] & bz[2]);

  assign en_o[0] = (excl_i != tmsas_pkg::AXIS_X);
  assign en_o[1] = (excl_i != tmsas_pkg::AXIS_Y);
  assign en_o[2] = (excl_i != tmsas_pkg::AXIS_Z);

  assign low_o = maj & en_o;

endmodule

`default_nettype wire

>>> hdl/tmsas_counter_bank.sv
`default_nettype none

module tmsas_counter_bank (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmsas_pkg::upd_t     upd_i,
  output tmsas_pkg::cnt_set_t cnt_o
);

  tmsas_pkg::cnt_set_t cnt_q, cnt_d, base;

  function automatic tmsas_pkg::count_t bump(tmsas_pkg::count_t c);
    return (c < tmsas_pkg::COUNT_CAP) ? c + tmsas_pkg::CNT_W'(1) : c;
  endfunction

  always_comb begin
    base  = upd_i.clear ? '0 : cnt_q;
    cnt_d = base;
    for (int k = 0; k < tmsas_pkg::NUM_AXES; k++) begin
      if (upd_i.step && upd_i.en[k]) begin
        if (upd_i.low[k]) begin
          cnt_d[k].lo = bump(base[k].lo);
        end else begin
          cnt_d[k].hi = bump(base[k].hi);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

>>> hdl/tmsas_decide.sv
`default_nettype none

module tmsas_decide (
  input  tmsas_pkg::cnt_set_t  cnt_i,
  input  logic [1:0]           excl_i,
  output tmsas_pkg::decision_t dec_o
);

  tmsas_pkg::count_t   diff [tmsas_pkg::NUM_AXES];
  logic [1:0]          axis;
  tmsas_pkg::side_cnt_t sel;
  logic [tmsas_pkg::CNT_W:0] n;
  logic [tmsas_pkg::CNT_W-1:0] half;

  always_comb begin
    for (int k = 0; k < tmsas_pkg::NUM_AXES; k++) begin
      diff[k] = (cnt_i[k].lo >= cnt_i[k].hi) ? cnt_i[k].lo - cnt_i[k].hi
                                             : cnt_i[k].hi - cnt_i[k].lo;
    end
  end

  // ties go to x, then y
  always_comb begin
    unique case (excl_i)
      tmsas_pkg::AXIS_X: axis = (diff[1] <= diff[2]) ? tmsas_pkg::AXIS_Y : tmsas_pkg::AXIS_Z;
      tmsas_pkg::AXIS_Y: axis = (diff[0] <= diff[2]) ? tmsas_pkg::AXIS_X : tmsas_pkg::AXIS_Z;
      tmsas_pkg::AXIS_Z: axis = (diff[0] <= diff[1]) ? tmsas_pkg::AXIS_X : tmsas_pkg::AXIS_Y;
      default: begin
        if (diff[0] <= diff[1] && diff[0] <= diff[2]) begin
          axis = tmsas_pkg::AXIS_X;
        end else if (diff[1] <= diff[2]) begin
          axis = tmsas_pkg::AXIS_Y;
        end else begin
          axis = tmsas_pkg::AXIS_Z;
        end
      end
    endcase
  end

  always_comb begin
    case (axis)
      tmsas_pkg::AXIS_X: sel = cnt_i[0];
      tmsas_pkg::AXIS_Y: sel = cnt_i[1];
      default:           sel = cnt_i[2];
    endcase
  end

  assign n    = {1'b0, sel.lo} + {1'b0, sel.hi};
  assign half = n[tmsas_pkg::CNT_W:1];

  always_comb begin
    dec_o.axis   = axis;
    dec_o.halves = (sel.lo == '0) || (sel.hi == '0);
    if (dec_o.halves) begin
      dec_o.lo = half;
      dec_o.hi = tmsas_pkg::CNT_W'(n - {1'b0, half});
    end else begin
      dec_o.lo = sel.lo;
      dec_o.hi = sel.hi;
    end
  end

endmodule

`default_nettype wire

>>> hdl/triangle_median_split_axis_select_unit.sv
// Median split axis selector for a stream of triangles.
// Channels: tri_i takes one triangle word (three corners, last flag),
// res_o gives one result word per triangle in order, cfg_i writes the
// box center (indexes 0..2) and the excluded axis (index 3); the user must
// write them only while idle, which the block does not enforce. A
// triangle accepted into the input register reaches res_o through the
// classify register and the output register. Throughput: one triangle
// per cycle unless res_o stalls, set by the counter bank update from classify.
// The result of the last triangle carries the chosen axis and the side
// counts; the counters restart from zero for the triangle after it.
// Reset: counters cleared, center at zero, no axis excluded, all
// pipeline stages empty.
// Stall: each stage holds while the next is full and not taking; while
// res_o is stalled the internal stages still fill, then tri_i.ready drops.
`default_nettype none
`include "triangle_median_split_axis_select_unit_assert.svh"

module triangle_median_split_axis_select_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  tmsas_tri_if.sink          tri_i,
  tmsas_cfg_if.sink          cfg_i,
  tmsas_res_if.source        res_o
);

  // configuration
  tmsas_pkg::coord_t center_x_q, center_y_q, center_z_q;
  logic [1:0]        excl_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      excl_q     <= tmsas_pkg::AXIS_NONE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        tmsas_pkg::REG_CENTER_X:      center_x_q <= cfg_i.data.data;
        tmsas_pkg::REG_CENTER_Y:      center_y_q <= cfg_i.data.data;
        tmsas_pkg::REG_CENTER_Z:      center_z_q <= cfg_i.data.data;
        tmsas_pkg::REG_EXCLUDED_AXIS: excl_q     <= cfg_i.data.data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_valid_q, b_valid_q, o_valid_q;
  logic a_ready, b_ready, o_ready;
  logic in_fire, a_fire, b_fire;

  tmsas_pkg::tri_t a_data_q;
  logic [tmsas_pkg::NUM_AXES-1:0] b_low_q;
  logic b_last_q;
  tmsas_pkg::res_t o_data_q;

  assign o_ready = !o_valid_q || res_o.ready;
  assign b_ready = !b_valid_q || o_ready;
  assign a_ready = !a_valid_q || b_ready;

  assign tri_i.ready = a_ready;
  assign in_fire = tri_i.valid && a_ready;
  assign a_fire  = a_valid_q && b_ready;
  assign b_fire  = b_valid_q && o_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= tri_i.valid;
      if (b_ready) b_valid_q <= a_valid_q;
      if (o_ready) o_valid_q <= b_valid_q;
    end
  end

  // classify
  logic [tmsas_pkg::NUM_AXES-1:0] en, low;

  tmsas_classify u_classify (
    .tri_i      (a_data_q),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .excl_i     (excl_q),
    .en_o       (en),
    .low_o      (low)
  );

  // counters
  tmsas_pkg::upd_t     upd;
  tmsas_pkg::cnt_set_t cnt;

  assign upd.step  = a_fire;
  assign upd.clear = b_fire && b_last_q;
  assign upd.en    = en;
  assign upd.low   = low;

  tmsas_counter_bank u_counter_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .cnt_o  (cnt)
  );

  // decision
  tmsas_pkg::decision_t dec;

  tmsas_decide u_decide (
    .cnt_i  (cnt),
    .excl_i (excl_q),
    .dec_o  (dec)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_data_q <= tri_i.data;
    end
    if (a_fire) begin
      b_low_q  <= low;
      b_last_q <= a_data_q.last_triangle;
    end
    if (b_fire) begin
      o_data_q.low_on_x       <= b_low_q[0];
      o_data_q.low_on_y       <= b_low_q[1];
      o_data_q.low_on_z       <= b_low_q[2];
      o_data_q.decision_valid <= b_last_q;
      o_data_q.chosen_axis    <= b_last_q ? dec.axis : tmsas_pkg::AXIS_X;
      o_data_q.use_index_halves <= b_last_q && dec.halves;
      o_data_q.low_count      <= b_last_q ? dec.lo : '0;
      o_data_q.high_count     <= b_last_q ? dec.hi : '0;
    end
  end

  assign res_o.valid = o_valid_q;
  assign res_o.data  = o_data_q;

  `TMSAS_ASSERT_SAME(a_plain_result_zero,
      res_o.valid && !res_o.data.decision_valid,
      res_o.data.chosen_axis == tmsas_pkg::AXIS_X && !res_o.data.use_index_halves &&
      res_o.data.low_count == '0 && res_o.data.high_count == '0,
      "decision fields set on a result that is not the last")
  `TMSAS_ASSERT_SAME(a_axis_allowed,
      res_o.valid && res_o.data.decision_valid,
      res_o.data.chosen_axis != excl_q && res_o.data.chosen_axis != tmsas_pkg::AXIS_NONE,
      "chosen axis is excluded or invalid")
  `TMSAS_ASSERT_SAME(a_halves_order,
      res_o.valid && res_o.data.use_index_halves,
      res_o.data.low_count <= res_o.data.high_count,
      "index halving gives a larger first part")
  `TMSAS_ASSERT_NEXT(a_clear_after_last,
      b_fire && b_last_q && !a_fire,
      cnt == '0,
      "counters not cleared after the last triangle")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;

  localparam tmsas_pkg::coord_t LO_C = 32'sh8000_0000;
  localparam tmsas_pkg::coord_t HI_C = 32'sh7FFF_FFFF;
  localparam tmsas_pkg::coord_t ONE_C = 32'sh0001_0000;
  localparam tmsas_pkg::coord_t JUST_BELOW_ONE = 32'sh0000_FFFF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES = 150;
  localparam int N_ROWS = 26;

  typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_FIXED} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    tmsas_pkg::cfg_t reg_w;
    tmsas_pkg::tri_t shape;
    tmsas_pkg::res_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tmsas_tri_if tri_if ();
  tmsas_cfg_if cfg_if ();
  tmsas_res_if res_if ();

  triangle_median_split_axis_select_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tri_i (tri_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the block
  tmsas_pkg::coord_t box_center [3];
  logic [1:0]        skip_axis;
  tmsas_pkg::count_t low_tally [3];
  tmsas_pkg::count_t high_tally [3];

  tmsas_pkg::res_t expected_splits [int];
  int              exp_wr = 0;
  int              exp_rd = 0;
  int              mismatches = 0;

  bit              calm = 1'b0;
  bit              hold_req = 1'b0;
  int              stall_left = 0;
  bit              fixed_pending = 1'b0;
  tmsas_pkg::res_t fixed_res = '0;

  plan_row_t plan [N_ROWS] = '{
    '{ROW_FIXED, '0, {{9{LO_C}}, 1'b0},
      '{1'b1, 1'b1, 1'b1, 1'b0, tmsas_pkg::AXIS_X, 1'b0, 17'd0, 17'd0}},
    '{ROW_FIXED, '0, {{9{HI_C}}, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1'b0, tmsas_pkg::AXIS_X, 1'b0, 17'd0, 17'd0}},
    '{ROW_FIXED, '0, {{9{32'sd0}}, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1, tmsas_pkg::AXIS_X, 1'b0, 17'd1, 17'd2}},
    '{ROW_FIXED, '0, {{9{LO_C}}, 1'b1},
      '{1'b1, 1'b1, 1'b1, 1'b1, tmsas_pkg::AXIS_X, 1'b1, 17'd0, 17'd1}},
    '{ROW_FIXED, '0,
      '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'sd5, 32'sd0, 32'sd5, 32'sd5, 32'sd0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, tmsas_pkg::AXIS_X, 1'b0, 17'd0, 17'd0}},
    '{ROW_PREDICT, '0,
      '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'sd7, 32'sd7, 32'sd7, 1'b1},
      '0},
    '{ROW_PREDICT, '0, {{9{-32'sd1}}, 1'b0}, '0},
    '{ROW_PREDICT, '0,
      '{-32'sd1, -32'sd1, 32'sd3, -32'sd1, -32'sd1, 32'sd3, -32'sd1, -32'sd1, 32'sd3, 1'b1},
      '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_X, HI_C}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_Y, ONE_C}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_Z, -32'sd1}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_EXCLUDED_AXIS, 32'(tmsas_pkg::AXIS_X)}, '0, '0},
    '{ROW_PREDICT, '0,
      '{32'sd0, JUST_BELOW_ONE, -32'sd2, HI_C, ONE_C, -32'sd1, LO_C, LO_C, -32'sd1, 1'b0},
      '0},
    '{ROW_PREDICT, '0,
      '{32'sd5, ONE_C, -32'sd2, 32'sd5, ONE_C, LO_C, 32'sd5, HI_C, -32'sd5, 1'b1},
      '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_X, LO_C}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_Z, LO_C}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_EXCLUDED_AXIS, 32'(tmsas_pkg::AXIS_Y)}, '0, '0},
    '{ROW_PREDICT, '0, {{9{LO_C}}, 1'b1}, '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_X, 32'sd0}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_Y, 32'sd0}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_EXCLUDED_AXIS, 32'(tmsas_pkg::AXIS_Z)}, '0, '0},
    '{ROW_PREDICT, '0,
      '{-32'sd1, 32'sd3, -32'sd1, -32'sd1, 32'sd3, -32'sd1, 32'sd1, 32'sd3, -32'sd1, 1'b0},
      '0},
    '{ROW_PREDICT, '0, {{9{-32'sd1}}, 1'b1}, '0},
    '{ROW_REG, '{tmsas_pkg::REG_CENTER_Z, 32'sd0}, '0, '0},
    '{ROW_REG, '{tmsas_pkg::REG_EXCLUDED_AXIS, 32'(tmsas_pkg::AXIS_NONE)}, '0, '0},
    '{ROW_PREDICT, '0,
      '{-32'sd4, 32'sd4, -32'sd4, 32'sd4, -32'sd4, -32'sd4, 32'sd4, 32'sd4, 32'sd4, 1'b1},
      '0}
  };

  function automatic tmsas_pkg::count_t bump(tmsas_pkg::count_t c);
    return (c < tmsas_pkg::COUNT_CAP) ? c + 1'b1 : c;
  endfunction

  function automatic tmsas_pkg::res_t predict_split(tmsas_pkg::tri_t t);
    tmsas_pkg::res_t   r;
    tmsas_pkg::coord_t ca [3];
    tmsas_pkg::coord_t cb [3];
    tmsas_pkg::coord_t cc [3];
    logic [2:0]        low;
    int                spread [3];
    int                below;
    logic [1:0]        ax;
    tmsas_pkg::count_t lo;
    tmsas_pkg::count_t hi;
    tmsas_pkg::count_t n;
    r = '0;
    low = '0;
    ca = '{t.v1_x, t.v1_y, t.v1_z};
    cb = '{t.v2_x, t.v2_y, t.v2_z};
    cc = '{t.v3_x, t.v3_y, t.v3_z};
    for (int a = 0; a < 3; a++) begin
      if (skip_axis != 2'(a)) begin
        below = int'(ca[a] < box_center[a]) + int'(cb[a] < box_center[a])
              + int'(cc[a] < box_center[a]);
        low[a] = (below >= 2);
        if (low[a]) low_tally[a] = bump(low_tally[a]);
        else high_tally[a] = bump(high_tally[a]);
      end
    end
    r.low_on_x = low[0];
    r.low_on_y = low[1];
    r.low_on_z = low[2];
    if (t.last_triangle) begin
      for (int a = 0; a < 3; a++) begin
        spread[a] = (low_tally[a] > high_tally[a]) ?
                    int'(low_tally[a]) - int'(high_tally[a]) :
                    int'(high_tally[a]) - int'(low_tally[a]);
      end
      case (skip_axis)
        tmsas_pkg::AXIS_X:
          ax = (spread[1] <= spread[2]) ? tmsas_pkg::AXIS_Y : tmsas_pkg::AXIS_Z;
        tmsas_pkg::AXIS_Y:
          ax = (spread[0] <= spread[2]) ? tmsas_pkg::AXIS_X : tmsas_pkg::AXIS_Z;
        tmsas_pkg::AXIS_Z:
          ax = (spread[0] <= spread[1]) ? tmsas_pkg::AXIS_X : tmsas_pkg::AXIS_Y;
        default: begin
          if (spread[0] <= spread[1] && spread[0] <= spread[2]) ax = tmsas_pkg::AXIS_X;
          else if (spread[1] <= spread[2]) ax = tmsas_pkg::AXIS_Y;
          else ax = tmsas_pkg::AXIS_Z;
        end
      endcase
      lo = low_tally[ax];
      hi = high_tally[ax];
      if (lo == 0 || hi == 0) begin
        n = lo + hi;
        lo = n >> 1;
        hi = n - lo;
        r.use_index_halves = 1'b1;
      end
      r.decision_valid = 1'b1;
      r.chosen_axis = ax;
      r.low_count = lo;
      r.high_count = hi;
      for (int a = 0; a < 3; a++) begin
        low_tally[a] = '0;
        high_tally[a] = '0;
      end
    end
    return r;
  endfunction

  task automatic compare_split(tmsas_pkg::res_t got, tmsas_pkg::res_t exp);
    if (got.low_on_x !== exp.low_on_x) begin
      $error("low_on_x: expected %0d, got %0d", exp.low_on_x, got.low_on_x);
      mismatches++;
    end
    if (got.low_on_y !== exp.low_on_y) begin
      $error("low_on_y: expected %0d, got %0d", exp.low_on_y, got.low_on_y);
      mismatches++;
    end
    if (got.low_on_z !== exp.low_on_z) begin
      $error("low_on_z: expected %0d, got %0d", exp.low_on_z, got.low_on_z);
      mismatches++;
    end
    if (got.decision_valid !== exp.decision_valid) begin
      $error("decision_valid: expected %0d, got %0d", exp.decision_valid, got.decision_valid);
      mismatches++;
    end
    if (got.chosen_axis !== exp.chosen_axis) begin
      $error("chosen_axis: expected %0d, got %0d", exp.chosen_axis, got.chosen_axis);
      mismatches++;
    end
    if (got.use_index_halves !== exp.use_index_halves) begin
      $error("use_index_halves: expected %0d, got %0d", exp.use_index_halves,
             got.use_index_halves);
      mismatches++;
    end
    if (got.low_count !== exp.low_count) begin
      $error("low_count: expected %0d, got %0d", exp.low_count, got.low_count);
      mismatches++;
    end
    if (got.high_count !== exp.high_count) begin
      $error("high_count: expected %0d, got %0d", exp.high_count, got.high_count);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    tmsas_pkg::res_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (exp_wr == exp_rd) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          compare_split(res_if.data, expected_splits[exp_rd]);
          expected_splits.delete(exp_rd);
          exp_rd++;
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.index == tmsas_pkg::REG_EXCLUDED_AXIS) begin
          skip_axis = cfg_if.data.data[1:0];
        end else begin
          box_center[cfg_if.data.index] = cfg_if.data.data;
        end
      end
      if (tri_if.valid && tri_if.ready) begin
        want = predict_split(tri_if.data);
        if (fixed_pending) want = fixed_res;
        expected_splits[exp_wr] = want;
        exp_wr++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          res_if.ready = 1'b0;
          stall_left = gap - 1;
        end else begin
          res_if.ready = 1'b1;
        end
      end
    end
  end

  task automatic send_tri(input tmsas_pkg::tri_t t, input bit fixed,
                          input tmsas_pkg::res_t exp);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    tri_if.data = t;
    fixed_pending = fixed;
    fixed_res = exp;
    tri_if.valid = 1'b1;
    @(posedge clk_i);
    while (!tri_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    tri_if.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    repeat (pick_gap()) @(negedge clk_i);
    cfg_if.data = '{idx, value};
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (exp_wr != exp_rd) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic tmsas_pkg::coord_t near_coord(tmsas_pkg::coord_t ctr);
    case ($urandom_range(0, 9))
      0: return LO_C;
      1: return HI_C;
      2, 3, 4, 5:
        return ctr + tmsas_pkg::coord_t'($urandom_range(0, 4)) - tmsas_pkg::coord_t'(2);
      default: return tmsas_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic tmsas_pkg::coord_t pick_center();
    case ($urandom_range(0, 7))
      0: return LO_C;
      1: return HI_C;
      2: return 32'sd0;
      3, 4: return tmsas_pkg::coord_t'($urandom_range(0, 32'h0010_0000))
                 - tmsas_pkg::coord_t'(32'h0008_0000);
      default: return tmsas_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_skip();
    case ($urandom_range(0, 5))
      0: return tmsas_pkg::AXIS_X;
      1: return tmsas_pkg::AXIS_Y;
      2: return tmsas_pkg::AXIS_Z;
      default: return tmsas_pkg::AXIS_NONE;
    endcase
  endfunction

  function automatic int pick_part_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 1;
    if (r < 17) return $urandom_range(2, 12);
    if (r < 19) return $urandom_range(30, 80);
    return $urandom_range(200, 400);
  endfunction

  function automatic tmsas_pkg::tri_t random_triangle(bit last);
    tmsas_pkg::tri_t t;
    t.v1_x = near_coord(box_center[0]);
    t.v1_y = near_coord(box_center[1]);
    t.v1_z = near_coord(box_center[2]);
    t.v2_x = near_coord(box_center[0]);
    t.v2_y = near_coord(box_center[1]);
    t.v2_z = near_coord(box_center[2]);
    t.v3_x = near_coord(box_center[0]);
    t.v3_y = near_coord(box_center[1]);
    t.v3_z = near_coord(box_center[2]);
    t.last_triangle = last;
    return t;
  endfunction

  initial begin
    #4_000_000;
    $display("triangle_median_split_axis_select_unit regression: fail");
    $finish;
  end

  initial begin
    int sent;
    int phase;
    int len;
    int part_left;
    box_center = '{32'sd0, 32'sd0, 32'sd0};
    skip_axis = tmsas_pkg::AXIS_NONE;
    low_tally = '{3{'0}};
    high_tally = '{3{'0}};
    tri_if.valid = 1'b0;
    tri_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: begin
          wait_idle();
          write_reg(plan[i].reg_w.index, plan[i].reg_w.data);
        end
        ROW_PREDICT: send_tri(plan[i].shape, 1'b0, '0);
        default: send_tri(plan[i].shape, 1'b1, plan[i].want);
      endcase
    end

    sent = 0;
    phase = 0;
    part_left = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      calm = 1'b0;
      if ($urandom_range(0, 2) == 0) write_reg(tmsas_pkg::REG_CENTER_X, pick_center());
      if ($urandom_range(0, 2) == 0) write_reg(tmsas_pkg::REG_CENTER_Y, pick_center());
      if ($urandom_range(0, 2) == 0) write_reg(tmsas_pkg::REG_CENTER_Z, pick_center());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(tmsas_pkg::REG_EXCLUDED_AXIS, 32'(pick_skip()));
      end
      calm = ($urandom_range(0, 4) == 0) || (phase == 4);
      // sender keeps pushing while the result side holds off
      if (phase == 4) hold_req = 1'b1;
      len = $urandom_range(40, 150);
      repeat (len) begin
        if (part_left == 0) part_left = pick_part_len();
        part_left--;
        send_tri(random_triangle(part_left == 0), 1'b0, '0);
        sent++;
      end
      phase++;
    end
    if (part_left != 0) send_tri(random_triangle(1'b1), 1'b0, '0);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("triangle_median_split_axis_select_unit regression: pass");
    end else begin
      $display("triangle_median_split_axis_select_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
